### rtl/core/tioiq_pkg.sv
package tioiq_pkg;

	// request function codes
	localparam logic [1:0] FUNC_PUSH     = 2'd0;
	localparam logic [1:0] FUNC_ISSUE    = 2'd1;
	localparam logic [1:0] FUNC_COMPLETE = 2'd2;

	// operation types
	localparam logic [2:0] TYPE_WRITE      = 3'd0;
	localparam logic [2:0] TYPE_READ       = 3'd1;
	localparam logic [2:0] TYPE_DISCONNECT = 3'd2;
	localparam logic [2:0] TYPE_SHUTDOWN   = 3'd3;
	localparam logic [2:0] TYPE_HANDSHAKE  = 3'd4;
	localparam int         NUM_TYPES       = 5;

	// ongoing counters saturate here
	localparam logic [1:0] ONGOING_MAX = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NONE     = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  op_type;
		logic [15:0] op_handle;
	} req_t;

	typedef struct packed {
		logic        issued;
		logic [2:0]  issued_type;
		logic [15:0] issued_handle;
		logic [1:0]  status;
		logic        write_queued;
	} rsp_t;

	// one pending queue entry
	typedef struct packed {
		logic [2:0]  op_type;
		logic [15:0] op_handle;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t entry;
	} fifo_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic write_queued;
	} fifo_stat_t;

	typedef struct packed {
		logic       issue;
		logic [2:0] issue_type;
		logic       complete;
		logic [2:0] comp_type;
	} trk_ctrl_t;

	typedef struct packed {
		logic issue_ok;
		logic any_ongoing;
		logic type_ongoing;
	} trk_stat_t;

endpackage

### rtl/core/typed_io_operation_issue_queue.sv
// Issue queue for typed connection operations.
// Request channel (req_valid, req_stall, req_data): each request is a push of
// an operation onto the pending queue, an attempt to issue the queue head, or
// the completion of an ongoing operation. Response channel (rsp_valid,
// rsp_stall, rsp_data): exactly one response per request, in request order,
// carrying the issued operation, a status code and whether a write is queued.
// A request taken into the request register has its response built
// combinationally and captured in the response register. Throughput is one
// request per cycle while the receiver does not stall: every request is
// resolved between the request register and the response register, touching
// only the queue head, the tail and the per-type ongoing counters.
// Reset empties the queue and clears all ongoing counts; queue storage is not
// cleared and only written entries are ever issued.
// When the receiver stalls, the response register holds its contents and the
// request register fills; after that req_stall is raised until rsp_stall
// drops, so no request is lost or repeated.
module typed_io_operation_issue_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  tioiq_pkg::req_t req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output tioiq_pkg::rsp_t rsp_data
);
	import tioiq_pkg::*;

	req_t       req_s1;
	logic       valid_s1;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       adv;
	logic       fire;
	logic       type_ok;
	logic       push_req;
	entry_t     head;
	fifo_ctrl_t fctrl;
	fifo_stat_t fstat;
	trk_ctrl_t  tctrl;
	trk_stat_t  tstat;
	rsp_t       rsp_d;

	// flow control
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// decode of the held request
	always_comb begin
		type_ok  = (req_s1.op_type <= TYPE_HANDSHAKE);
		push_req = fire && req_s1.func == FUNC_PUSH && type_ok;

		fctrl.push  = push_req && !fstat.full;
		fctrl.entry = '{op_type: req_s1.op_type, op_handle: req_s1.op_handle};

		tctrl.issue      = fire && req_s1.func == FUNC_ISSUE && !fstat.empty &&
			head.op_type <= TYPE_HANDSHAKE && tstat.issue_ok;
		tctrl.issue_type = head.op_type;
		tctrl.complete   = fire && req_s1.func == FUNC_COMPLETE && tstat.any_ongoing &&
			type_ok && tstat.type_ongoing;
		tctrl.comp_type  = req_s1.op_type;

		fctrl.pop = tctrl.issue;
	end

	// response assembly
	always_comb begin
		rsp_d               = '0;
		rsp_d.issued        = tctrl.issue;
		rsp_d.write_queued  = fstat.write_queued;
		if (tctrl.issue) begin
			rsp_d.issued_type   = head.op_type;
			rsp_d.issued_handle = head.op_handle;
		end
		rsp_d.status = STATUS_OK;
		case (req_s1.func)
			FUNC_PUSH: begin
				if (push_req && fstat.full) begin
					rsp_d.status = STATUS_OVERFLOW;
				end
			end
			FUNC_COMPLETE: begin
				if (!tstat.any_ongoing) begin
					rsp_d.status = STATUS_NONE;
				end else if (!type_ok || !tstat.type_ongoing) begin
					rsp_d.status = STATUS_MISMATCH;
				end
			end
			default: begin
				rsp_d.status = STATUS_OK;
			end
		endcase
	end

	tioiq_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fctrl),
		.head_entry(head),
		.stat      (fstat)
	);

	tioiq_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_type(head.op_type),
		.ctrl     (tctrl),
		.stat     (tstat)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

### rtl/core/tioiq_fifo.sv
module tioiq_fifo #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tioiq_pkg::fifo_ctrl_t ctrl,
	output tioiq_pkg::entry_t   head_entry,
	output tioiq_pkg::fifo_stat_t stat
);
	import tioiq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

	entry_t          mem [QUEUE_DEPTH];
	entry_t          rd_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   head_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CW-1:0]   wcount_q;
	logic [CW-1:0]   wcount_d;
	logic [AW:0]     tail_sum;
	logic [AW:0]     head_inc;
	logic [AW-1:0]   tail;

	// tail position, wrapped at the queue depth
	always_comb begin
		tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
		if (tail_sum >= DEPTH_W) begin
			tail = AW'(tail_sum - DEPTH_W);
		end else begin
			tail = tail_sum[AW-1:0];
		end
	end

	// next head pointer
	always_comb begin
		head_inc = {1'b0, head_q} + (AW + 1)'(1);
		head_d   = head_q;
		if (ctrl.pop) begin
			if (head_inc == DEPTH_W) begin
				head_d = '0;
			end else begin
				head_d = head_inc[AW-1:0];
			end
		end
	end

	// fill and write counts
	always_comb begin
		count_d  = count_q;
		wcount_d = wcount_q;
		if (ctrl.push) begin
			count_d = count_q + CW'(1);
			if (ctrl.entry.op_type == TYPE_WRITE) begin
				wcount_d = wcount_q + CW'(1);
			end
		end else if (ctrl.pop) begin
			count_d = count_q - CW'(1);
			if (rd_q.op_type == TYPE_WRITE && wcount_q != '0) begin
				wcount_d = wcount_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			wcount_q <= '0;
		end else begin
			head_q   <= head_d;
			count_q  <= count_d;
			wcount_q <= wcount_d;
		end
	end

	// storage, head entry read ahead with write forwarding
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail] <= ctrl.entry;
		end
		if (ctrl.push && tail == head_d) begin
			rd_q <= ctrl.entry;
		end else begin
			rd_q <= mem[head_d];
		end
	end

	assign head_entry        = rd_q;
	assign stat.empty        = (count_q == '0);
	assign stat.full         = (count_q == DEPTH_C);
	assign stat.write_queued = (wcount_d != '0);

endmodule

### rtl/core/tioiq_track.sv
module tioiq_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           head_type,
	input  tioiq_pkg::trk_ctrl_t ctrl,
	output tioiq_pkg::trk_stat_t stat
);
	import tioiq_pkg::*;

	logic [1:0] cnt_q [NUM_TYPES];
	logic       blk_all;
	logic       blk_read;

	// conflict check against the ongoing set
	always_comb begin
		blk_all  = (cnt_q[TYPE_WRITE] != '0) || (cnt_q[TYPE_DISCONNECT] != '0) ||
			(cnt_q[TYPE_SHUTDOWN] != '0) || (cnt_q[TYPE_HANDSHAKE] != '0);
		blk_read = (cnt_q[TYPE_READ] != '0) &&
			(head_type inside {TYPE_READ, TYPE_HANDSHAKE});
		stat.issue_ok     = !blk_all && !blk_read;
		stat.any_ongoing  = blk_all || (cnt_q[TYPE_READ] != '0);
		stat.type_ongoing = 1'b0;
		for (int i = 0; i < NUM_TYPES; i++) begin
			if (ctrl.comp_type == 3'(i) && cnt_q[i] != '0) begin
				stat.type_ongoing = 1'b1;
			end
		end
	end

	// per-type ongoing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TYPES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_TYPES; i++) begin
				if (ctrl.issue && ctrl.issue_type == 3'(i) && cnt_q[i] != ONGOING_MAX) begin
					cnt_q[i] <= cnt_q[i] + 2'd1;
				end else if (ctrl.complete && ctrl.comp_type == 3'(i) && cnt_q[i] != '0) begin
					cnt_q[i] <= cnt_q[i] - 2'd1;
				end
			end
		end
	end

endmodule
